// ===== hdl/sbss_pkg.sv =====
// Shared types and constants for the song bytecode step sequencer.
`timescale 1ns / 1ps

package sbss_pkg;

  // request operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_FETCH      = 3'd0;
  localparam logic [2:0] KIND_NOTE_START = 3'd1;
  localparam logic [2:0] KIND_NOTE_END   = 3'd2;
  localparam logic [2:0] KIND_INSTRUMENT = 3'd3;
  localparam logic [2:0] KIND_VOLUME     = 3'd4;
  localparam logic [2:0] KIND_LED_ON     = 3'd5;
  localparam logic [2:0] KIND_LED_OFF    = 3'd6;
  localparam logic [2:0] KIND_ENDED      = 3'd7;

  // song opcodes (high nibble of a command byte)
  localparam logic [3:0] SONG_END_CODE       = 4'd8;
  localparam logic [3:0] REST_CODE           = 4'd9;
  localparam logic [3:0] SET_CHANNELS_CODE   = 4'd10;
  localparam logic [3:0] SET_INSTRUMENT_CODE = 4'd11;
  localparam logic [3:0] SET_VOLUME_CODE     = 4'd12;
  localparam logic [3:0] SET_SPEED_CODE      = 4'd13;

  // reset values
  localparam logic [7:0] TICKS_PER_STEP_RESET = 8'd10;
  localparam logic [3:0] CHANNELS_RESET       = 4'd4;
  localparam logic [7:0] STEPS_PER_BEAT_RESET = 8'd4;

  // queue between front and back, in bundles
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] start_address;
    logic [7:0]  song_byte;
  } request_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] fetch_address;
    logic [3:0]  channel;
    logic [7:0]  value;
    logic        last;
  } result_t;

  // all results caused by one request, oldest in slot 0
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     slot;
  } bundle_t;

endpackage

// ===== hdl/sbss_front.sv =====
// Front end: accepts requests, runs the song parser state and builds result bundles.
`timescale 1ns / 1ps

module sbss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sbss_pkg::request_t  request,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  output logic                bundle_push,
  output sbss_pkg::bundle_t   bundle
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_ARG  = 2'd2;
  localparam logic [1:0] PH_NOTE = 2'd3;

  logic [7:0]  steps_per_beat;
  logic [7:0]  tick_count, tick_count_next;
  logic [7:0]  ticks_per_step, ticks_per_step_next;
  logic        step_pending, step_pending_next;
  logic        playing, playing_next;
  logic [15:0] song_address, song_address_next;
  logic [3:0]  channels_in_use, channels_in_use_next;
  logic [7:0]  step_in_beat, step_in_beat_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic [3:0]  held_argument, held_argument_next;
  logic [3:0]  note_index, note_index_next;

  function automatic sbss_pkg::result_t mk(input logic [2:0] kind, input logic [15:0] addr,
                                           input logic [3:0] ch, input logic [7:0] val);
    sbss_pkg::result_t r;
    r.kind          = kind;
    r.fetch_address = addr;
    r.channel       = ch;
    r.value         = val;
    r.last          = 1'b0;
    return r;
  endfunction

  // three ordered slots: mixer/led-off result, step-level result, step-start fetch
  sbss_pkg::result_t ca, cb, cc;
  logic              va, vb, vc;
  logic              do_end_step, allow_try;
  logic [3:0]        op_hi, arg_lo, ni;
  logic [7:0]        sib, tc1, b;
  logic [1:0]        cnt;

  always_comb begin
    tick_count_next      = tick_count;
    ticks_per_step_next  = ticks_per_step;
    step_pending_next    = step_pending;
    playing_next         = playing;
    song_address_next    = song_address;
    channels_in_use_next = channels_in_use;
    step_in_beat_next    = step_in_beat;
    parse_phase_next     = parse_phase;
    held_opcode_next     = held_opcode;
    held_argument_next   = held_argument;
    note_index_next      = note_index;
    ca = '0; cb = '0; cc = '0;
    va = 1'b0; vb = 1'b0; vc = 1'b0;
    do_end_step = 1'b0;
    allow_try   = 1'b0;
    b      = request.song_byte;
    op_hi  = b[7:4];
    arg_lo = b[3:0];
    ni     = note_index + 4'd1;
    tc1    = tick_count + 8'd1;
    sib    = step_in_beat + 8'd1;

    case (request.operation)
      sbss_pkg::OP_TICK: begin
        if (tc1 == ticks_per_step) begin
          tick_count_next   = '0;
          step_pending_next = 1'b1;
        end else begin
          tick_count_next = tc1;
        end
        allow_try = 1'b1;
      end
      sbss_pkg::OP_START: begin
        parse_phase_next  = PH_IDLE;
        song_address_next = request.start_address;
        playing_next      = 1'b1;
        allow_try         = 1'b1;
      end
      sbss_pkg::OP_BYTE: begin
        case (parse_phase)
          PH_CMD: begin
            if (op_hi == sbss_pkg::SONG_END_CODE) begin
              playing_next     = 1'b0;
              parse_phase_next = PH_IDLE;
              va = 1'b1; ca = mk(sbss_pkg::KIND_LED_OFF, '0, '0, '0);
              vb = 1'b1; cb = mk(sbss_pkg::KIND_ENDED, '0, '0, '0);
            end else if (op_hi == sbss_pkg::REST_CODE) begin
              song_address_next = song_address + 16'd1;
              do_end_step       = 1'b1;
            end else if (op_hi == sbss_pkg::SET_CHANNELS_CODE) begin
              channels_in_use_next = arg_lo;
              song_address_next    = song_address + 16'd1;
              vb = 1'b1; cb = mk(sbss_pkg::KIND_FETCH, song_address + 16'd1, '0, '0);
            end else if (op_hi == sbss_pkg::SET_INSTRUMENT_CODE ||
                         op_hi == sbss_pkg::SET_VOLUME_CODE ||
                         op_hi == sbss_pkg::SET_SPEED_CODE) begin
              held_opcode_next   = op_hi;
              held_argument_next = arg_lo;
              parse_phase_next   = PH_ARG;
              vb = 1'b1; cb = mk(sbss_pkg::KIND_FETCH, song_address + 16'd1, '0, '0);
            end else if (channels_in_use == 4'd0) begin
              do_end_step = 1'b1;
            end else begin
              // note row, this byte is channel 0
              if (b > 8'd1 && b < 8'd128) begin
                va = 1'b1; ca = mk(sbss_pkg::KIND_NOTE_START, '0, 4'd0, b);
              end else if (b == 8'd1) begin
                va = 1'b1; ca = mk(sbss_pkg::KIND_NOTE_END, '0, 4'd0, '0);
              end
              note_index_next = 4'd1;
              if (4'd1 >= channels_in_use) begin
                song_address_next = song_address + 16'(channels_in_use);
                do_end_step       = 1'b1;
              end else begin
                parse_phase_next = PH_NOTE;
                vb = 1'b1; cb = mk(sbss_pkg::KIND_FETCH, song_address + 16'd1, '0, '0);
              end
            end
          end
          PH_ARG: begin
            song_address_next = song_address + 16'd2;
            parse_phase_next  = PH_CMD;
            if (held_opcode == sbss_pkg::SET_INSTRUMENT_CODE) begin
              va = 1'b1; ca = mk(sbss_pkg::KIND_INSTRUMENT, '0, held_argument, b);
            end else if (held_opcode == sbss_pkg::SET_VOLUME_CODE) begin
              va = 1'b1; ca = mk(sbss_pkg::KIND_VOLUME, '0, held_argument, b);
            end else begin
              ticks_per_step_next = b;
            end
            vb = 1'b1; cb = mk(sbss_pkg::KIND_FETCH, song_address + 16'd2, '0, '0);
          end
          PH_NOTE: begin
            if (b > 8'd1 && b < 8'd128) begin
              va = 1'b1; ca = mk(sbss_pkg::KIND_NOTE_START, '0, note_index, b);
            end else if (b == 8'd1) begin
              va = 1'b1; ca = mk(sbss_pkg::KIND_NOTE_END, '0, note_index, '0);
            end
            note_index_next = ni;
            if (ni >= channels_in_use) begin
              song_address_next = song_address + 16'(channels_in_use);
              do_end_step       = 1'b1;
            end else begin
              parse_phase_next = PH_NOTE;
              vb = 1'b1; cb = mk(sbss_pkg::KIND_FETCH, song_address + 16'(ni), '0, '0);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (do_end_step) begin
      parse_phase_next = PH_IDLE;
      vb = 1'b1;
      if (sib == steps_per_beat) begin
        step_in_beat_next = '0;
        cb = mk(sbss_pkg::KIND_LED_ON, '0, '0, '0);
      end else begin
        step_in_beat_next = sib;
        cb = mk(sbss_pkg::KIND_LED_OFF, '0, '0, '0);
      end
      allow_try = 1'b1;
    end

    if (allow_try && step_pending_next && playing_next && parse_phase_next == PH_IDLE) begin
      step_pending_next = 1'b0;
      parse_phase_next  = PH_CMD;
      vc = 1'b1; cc = mk(sbss_pkg::KIND_FETCH, song_address_next, '0, '0);
    end

    // pack the live slots to the front
    cnt = 2'(va) + 2'(vb) + 2'(vc);
    bundle.count   = cnt;
    bundle.slot[0] = va ? ca : (vb ? cb : cc);
    bundle.slot[1] = (va && vb) ? cb : cc;
    bundle.slot[2] = cc;
    case (cnt)
      2'd1:    bundle.slot[0].last = 1'b1;
      2'd2:    bundle.slot[1].last = 1'b1;
      2'd3:    bundle.slot[2].last = 1'b1;
      default: begin
      end
    endcase
    bundle_push = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_beat  <= sbss_pkg::STEPS_PER_BEAT_RESET;
      tick_count      <= '0;
      ticks_per_step  <= sbss_pkg::TICKS_PER_STEP_RESET;
      step_pending    <= 1'b0;
      playing         <= 1'b0;
      song_address    <= '0;
      channels_in_use <= sbss_pkg::CHANNELS_RESET;
      step_in_beat    <= '0;
      parse_phase     <= PH_IDLE;
      held_opcode     <= '0;
      held_argument   <= '0;
      note_index      <= '0;
    end else begin
      if (cfg_write) begin
        steps_per_beat <= cfg_data;
      end
      if (accept) begin
        tick_count      <= tick_count_next;
        ticks_per_step  <= ticks_per_step_next;
        step_pending    <= step_pending_next;
        playing         <= playing_next;
        song_address    <= song_address_next;
        channels_in_use <= channels_in_use_next;
        step_in_beat    <= step_in_beat_next;
        parse_phase     <= parse_phase_next;
        held_opcode     <= held_opcode_next;
        held_argument   <= held_argument_next;
        note_index      <= note_index_next;
      end
    end
  end

endmodule

// ===== hdl/sbss_fifo.sv =====
// Small bundle queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module sbss_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sbss_pkg::bundle_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output sbss_pkg::bundle_t  head
);

  sbss_pkg::bundle_t             mem [sbss_pkg::QUEUE_DEPTH];
  logic [sbss_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [sbss_pkg::QUEUE_AW:0]   count;
  logic                          do_push, do_pop;

  assign full    = (count == (sbss_pkg::QUEUE_AW+1)'(sbss_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + (sbss_pkg::QUEUE_AW)'(1);
      if (do_pop)  rd_ptr <= rd_ptr + (sbss_pkg::QUEUE_AW)'(1);
      if (do_push && !do_pop)      count <= count + (sbss_pkg::QUEUE_AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (sbss_pkg::QUEUE_AW+1)'(1);
    end
  end

endmodule

// ===== hdl/sbss_back.sv =====
// Back end: walks each bundle and presents its results one at a time.
`timescale 1ns / 1ps

module sbss_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sbss_pkg::bundle_t  q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output sbss_pkg::result_t  result
);

  sbss_pkg::bundle_t cur;
  logic              cur_valid;
  logic [1:0]        idx;
  logic              at_last, load;

  assign at_last = (idx == cur.count - 2'd1);
  // refill when nothing is shown or the last result of the bundle leaves
  assign load    = !cur_valid || (pop && at_last);
  assign q_pop   = load && !q_empty;
  assign empty   = !cur_valid;
  assign result  = cur.slot[idx];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < cur.count))
    else $error("result index past bundle count");

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 2'd0))
    else $error("empty bundle reached the back end");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (result.last == at_last))
    else $error("last flag does not match bundle end");

endmodule

// ===== hdl/song_bytecode_step_sequencer.sv =====
// Top level of the song bytecode step sequencer.
//
//  channel   signals                          direction  moves
//  request   push, full, request              in         tick, start, song byte
//  result    empty, pop, result               out        fetch, mixer, led, ended
//  config    cfg_valid, cfg_ready, cfg_data   in         steps_per_beat
//
// One request is taken every cycle while full is low; the front end settles all
// parser state in that cycle and queues a bundle of one to three results, if any.
// The back end shows one result per cycle while pop is high; each result stays
// until popped; the four-bundle queue absorbs bursts and full rises when it fills.
// Synchronous reset clears parser state, queue and output; cfg_ready is always high.
`timescale 1ns / 1ps

module song_bytecode_step_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sbss_pkg::request_t  request,
  output logic                empty,
  input  logic                pop,
  output sbss_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic              accept, bundle_push, q_full, q_empty, q_pop;
  sbss_pkg::bundle_t bundle, q_head;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  sbss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .request     (request),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  sbss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (bundle_push),
    .push_data (bundle),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sbss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
